// ===== rtl/fmc_pkg.sv =====
// ----------------------------------------------------------------------------
// fmc_pkg: shared constants and types for the file magic classifier
// Holds the window sizes, the count limit and the result structure.
// ----------------------------------------------------------------------------
`default_nettype none
package fmc_pkg;
  localparam int unsigned HeadBytes      = 16;
  localparam int unsigned TailBytes      = 8;
  localparam int unsigned TarBytes       = 8;
  localparam int unsigned TarMagicOffset = 257;
  localparam int unsigned CountMax       = TarMagicOffset + TarBytes;
  localparam int unsigned CountW         = 9;

  typedef struct packed {
    logic       tail_ok;
    logic [4:0] confidence;
    logic       binary_flag;
    logic [3:0] category;
    logic [5:0] format_id;
    logic       detected;
  } result_t;

  // trailer kinds
  localparam logic [2:0] TrlNone = 3'd0;
  localparam logic [2:0] TrlPng  = 3'd1;
  localparam logic [2:0] TrlGif  = 3'd2;
  localparam logic [2:0] TrlJpeg = 3'd3;
  localparam logic [2:0] TrlPdf  = 3'd4;
endpackage
`default_nettype wire

// ===== rtl/fmc_match.sv =====
// ----------------------------------------------------------------------------
// fmc_match: combinational classification
// Compares the head, tar and tail windows against the known signatures.
// ----------------------------------------------------------------------------
`default_nettype none
module fmc_match #(
  parameter int unsigned HEAD_BYTES = fmc_pkg::HeadBytes,
  parameter int unsigned TAIL_BYTES = fmc_pkg::TailBytes
) (
  input  wire logic [HEAD_BYTES-1:0][7:0]     head_i,
  input  wire logic [fmc_pkg::TarBytes-1:0][7:0] tar_i,
  input  wire logic [TAIL_BYTES-1:0][7:0]     tail_i,
  input  wire logic [fmc_pkg::CountW-1:0]     len_i,
  input  wire logic                           check_trailer_i,
  output fmc_pkg::result_t                    result_o
);
  logic [31:0] w0, w4, w8;
  logic [15:0] h0;
  logic        l2, l3, l4, l5, l6, l7, l8, l12, l16, ltar;
  logic        hit;
  logic [5:0]  id;
  logic [3:0]  cls;
  logic        bin;
  logic [4:0]  conf;
  logic [2:0]  trl;
  logic        tv;

  function automatic logic [31:0] w4b(input logic [7:0] a, b, c, d);
    return {a, b, c, d};
  endfunction

  always_comb begin
    w0  = w4b(head_i[0], head_i[1], head_i[2], head_i[3]);
    w4  = w4b(head_i[4], head_i[5], head_i[6], head_i[7]);
    w8  = w4b(head_i[8], head_i[9], head_i[10], head_i[11]);
    h0  = w0[31:16];
    l2  = len_i >= 9'd2;  l3 = len_i >= 9'd3;  l4 = len_i >= 9'd4;
    l5  = len_i >= 9'd5;  l6 = len_i >= 9'd6;  l7 = len_i >= 9'd7;
    l8  = len_i >= 9'd8;  l12 = len_i >= 9'd12; l16 = len_i >= 9'd16;
    ltar = len_i >= 9'(fmc_pkg::CountMax);
    hit = 1'b1; id = '0; cls = '0; bin = 1'b1; conf = 5'd8; trl = fmc_pkg::TrlNone;
    tv  = 1'b1;
    if (!l2) begin
      hit = 1'b0;
    end else if (l12 && w4 == "ftyp") begin
      priority if (w8 == "avif") begin id = 6'd42; cls = 4'd1; end
      else if (w8 == "avis") begin id = 6'd43; cls = 4'd1; end
      else if (w8 == "heic" || w8 == "heix") begin id = 6'd44; cls = 4'd1; end
      else if (w8 == "hevc" || w8 == "hevx") begin id = 6'd45; cls = 4'd1; end
      else if (w8 == "mif1") begin id = 6'd46; cls = 4'd1; end
      else if (w8 == "mp41" || w8 == "mp42" || w8 == "isom" || w8 == "iso2" ||
               w8 == "avc1" || w8 == "mp71") begin id = 6'd47; cls = 4'd2; end
      else if (w8 == "M4V " || w8 == "m4v ") begin id = 6'd48; cls = 4'd2; end
      else if (w8 == "M4A " || w8 == "m4a ") begin id = 6'd49; cls = 4'd3; end
      else if (w8 == "M4B ") begin id = 6'd50; cls = 4'd3; end
      else if (w8 == "qt  ") begin id = 6'd51; cls = 4'd2; end
      else if (w8[31:8] == "3gp" || w8[31:8] == "3g2") begin id = 6'd52; cls = 4'd2; end
      else if (w8 == "dash") begin id = 6'd53; cls = 4'd2; end
      else begin id = 6'd54; cls = 4'd9; end
    end else if (l12 && w0 == "RIFF") begin
      priority if (w8 == "WEBP") begin id = 6'd38; cls = 4'd1; end
      else if (w8 == "WAVE") begin id = 6'd39; cls = 4'd3; end
      else if (w8 == "AVI ") begin id = 6'd40; cls = 4'd2; end
      else begin id = 6'd37; cls = 4'd9; end
    end else if (ltar && ({tar_i[0], tar_i[1], tar_i[2], tar_i[3], tar_i[4], tar_i[5]}
                 == {"ustar", 8'h00} ||
                 {tar_i[0], tar_i[1], tar_i[2], tar_i[3], tar_i[4], tar_i[5], tar_i[6],
                  tar_i[7]} == {"ustar  ", 8'h00})) begin
      id = 6'd41; cls = 4'd4; conf = 5'd6;
    end else if (l16 && {w0, w4, w8} == "SQLite forma" &&
                 {head_i[12], head_i[13], head_i[14], head_i[15]} == {"t 3", 8'h00}) begin
      id = 6'd36; cls = 4'd8; conf = 5'd16;
    end else if (l8 && {w0, w4} == 64'h89504E470D0A1A0A) begin
      id = 6'd1; cls = 4'd1; trl = fmc_pkg::TrlPng;
    end else if (l8 && {w0, w4} == 64'h526172211A070100) begin
      id = 6'd15; cls = 4'd4;
    end else if (l7 && {w0, w4[31:8]} == 56'h526172211A0700) begin
      id = 6'd15; cls = 4'd4; conf = 5'd7;
    end else if (l6 && ({w0, w4[31:16]} == "GIF89a" || {w0, w4[31:16]} == "GIF87a")) begin
      id = 6'd2; cls = 4'd1; conf = 5'd6; trl = fmc_pkg::TrlGif;
    end else if (l6 && {w0, w4[31:16]} == 48'h377ABCAF271C) begin
      id = 6'd16; cls = 4'd4; conf = 5'd6;
    end else if (l6 && {w0, w4[31:16]} == 48'hFD377A585A00) begin
      id = 6'd17; cls = 4'd4; conf = 5'd6;
    end else if (l5 && {w0, w4[31:24]} == "%PDF-") begin
      id = 6'd23; cls = 4'd5; conf = 5'd5; trl = fmc_pkg::TrlPdf;
    end else if (l5 && {w0, w4[31:24]} == 40'h7B5C727466) begin
      id = 6'd24; cls = 4'd5; conf = 5'd5; bin = 1'b0;
    end else if (l5 && {w0, w4[31:24]} == "<?xml") begin
      id = 6'd25; cls = 4'd5; conf = 5'd5; bin = 1'b0;
    end else begin
      conf = 5'd4;
      priority if (l4 && (w0 == 32'hFFD8FFE0 || w0 == 32'hFFD8FFE1)) begin
        id = 6'd3; cls = 4'd1; trl = fmc_pkg::TrlJpeg; end
      else if (l4 && w0 == 32'h00000100) begin id = 6'd5; cls = 4'd1; end
      else if (l4 && w0 == 32'h00000200) begin id = 6'd6; cls = 4'd1; end
      else if (l4 && (w0 == 32'h49492A00 || w0 == 32'h4D4D002A)) begin
        id = 6'd7; cls = 4'd1; end
      else if (l4 && w0 == "8BPS") begin id = 6'd8; cls = 4'd1; end
      else if (l4 && w0 == 32'h1A45DFA3) begin id = 6'd9; cls = 4'd2; end
      else if (l4 && w0 == 32'h464C5601) begin id = 6'd10; cls = 4'd2; end
      else if (l4 && w0 == "fLaC") begin id = 6'd11; cls = 4'd3; end
      else if (l4 && w0 == "OggS") begin id = 6'd12; cls = 4'd3; end
      else if (l4 && w0 == "MThd") begin id = 6'd13; cls = 4'd3; end
      else if (l4 && (w0 == 32'h504B0304 || w0 == 32'h504B0506 || w0 == 32'h504B0708))
        begin id = 6'd18; cls = 4'd4; end
      else if (l4 && w0 == 32'h28B52FFD) begin id = 6'd19; cls = 4'd4; end
      else if (l4 && w0 == 32'h04224D18) begin id = 6'd20; cls = 4'd4; end
      else if (l4 && w0 == "wOF2") begin id = 6'd27; cls = 4'd6; end
      else if (l4 && w0 == "wOFF") begin id = 6'd28; cls = 4'd6; end
      else if (l4 && w0 == "OTTO") begin id = 6'd29; cls = 4'd6; end
      else if (l4 && w0 == 32'h00010000) begin id = 6'd30; cls = 4'd6; end
      else if (l4 && w0 == 32'h0061736D) begin id = 6'd31; cls = 4'd7; end
      else if (l4 && w0 == 32'h7F454C46) begin id = 6'd32; cls = 4'd7; end
      else if (l4 && (w0 == 32'hFEEDFACF || w0 == 32'hFEEDFACE || w0 == 32'hCFFAEDFE ||
               w0 == 32'hCEFAEDFE)) begin id = 6'd33; cls = 4'd7; end
      else if (l4 && w0 == 32'hCAFEBABE) begin id = 6'd34; cls = 4'd7; end
      else if (l4 && w0 == 32'h6465780A) begin id = 6'd35; cls = 4'd7; end
      else if (l4 && w0 == "RIFF") begin id = 6'd37; cls = 4'd9; end
      else if (l3 && w0[31:8] == 24'hFFD8FF) begin
        id = 6'd3; cls = 4'd1; conf = 5'd3; trl = fmc_pkg::TrlJpeg; end
      else if (l3 && w0[31:8] == "ID3") begin id = 6'd14; cls = 4'd3; conf = 5'd3; end
      else if (l3 && w0[31:8] == "BZh") begin id = 6'd21; cls = 4'd4; conf = 5'd3; end
      else if (h0 == "BM") begin id = 6'd4; cls = 4'd1; conf = 5'd2; end
      else if (h0 == 16'hFFFB || h0 == 16'hFFFA || h0 == 16'hFFF3) begin
        id = 6'd14; cls = 4'd3; conf = 5'd2; end
      else if (h0 == 16'h1F8B) begin id = 6'd22; cls = 4'd4; conf = 5'd2; end
      else if (h0 == "%!") begin id = 6'd26; cls = 4'd5; conf = 5'd2; end
      else hit = 1'b0;
    end

    // trailer: tail_i[0] is the newest byte
    if (check_trailer_i) begin
      unique case (trl)
        fmc_pkg::TrlPng: tv = l8 && {tail_i[7], tail_i[6], tail_i[5], tail_i[4],
                                     tail_i[3], tail_i[2], tail_i[1], tail_i[0]}
                                    == 64'h49454E44AE426082;
        fmc_pkg::TrlGif:  tv = {tail_i[1], tail_i[0]} == 16'h003B;
        fmc_pkg::TrlJpeg: tv = {tail_i[1], tail_i[0]} == 16'hFFD9;
        fmc_pkg::TrlPdf:  tv = l5 && {tail_i[4], tail_i[3], tail_i[2], tail_i[1],
                                      tail_i[0]} == "%%EOF";
        default:          tv = 1'b1;
      endcase
    end

    if (hit) begin
      result_o = '{tail_ok: tv, confidence: conf, binary_flag: bin,
                   category: cls, format_id: id, detected: 1'b1};
    end else begin
      result_o = '0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/file_magic_classifier_top.sv =====
// ----------------------------------------------------------------------------
// file_magic_classifier_top: stream file-type detector
// Classifies a byte stream by its magic numbers and trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one byte per word on s_axis (tdata = data_byte, tlast = last_byte).
//   Each word updates the head window (bytes 0..15), the tar window (bytes
//   257..264), the tail window (last 8 bytes) and a length count that
//   saturates at 265. Non-final words produce nothing.
//   The final word is classified in the same cycle from the windows plus the
//   incoming byte; the result is registered and offered on m_axis in the next
//   cycle. tdata fields, low bit up: detected, format_id[6], category[4],
//   binary_flag, confidence[5], tail_ok (18 bits, padded to 24).
//   Throughput: one byte per cycle. The output register drains in the same
//   cycle it refills, so stalls cost nothing unless m_axis_tready stays low
//   while a result waits; then s_axis_tready drops and input holds.
//   cfg: one-bit check_trailer register, written with cfg_valid_i/cfg_ready_o
//   (always ready). Reset clears the count, the output valid and the register.
// ----------------------------------------------------------------------------
`default_nettype none
module file_magic_classifier_top #(
  parameter int unsigned HEAD_BYTES = fmc_pkg::HeadBytes,
  parameter int unsigned TAIL_BYTES = fmc_pkg::TailBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // data_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [23:0] m_axis_tdata_o,   // detected, format_id, category,
                                             // binary_flag, confidence, tail_ok
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic        cfg_data_i        // check_trailer
);
  localparam int unsigned CW = fmc_pkg::CountW;

  logic [HEAD_BYTES-1:0][7:0]        head_q, head_d;
  logic [fmc_pkg::TarBytes-1:0][7:0] tar_q, tar_d;
  logic [TAIL_BYTES-1:0][7:0]        tail_q, tail_d;
  logic [CW-1:0]                     count_q, count_d, len;
  logic                              check_q;
  logic                              out_valid_q;
  fmc_pkg::result_t                  res_q, res_d;
  logic                              accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Advance the windows with the incoming byte.
  always_comb begin
    head_d = head_q;
    tar_d  = tar_q;
    if (count_q < CW'(HEAD_BYTES)) head_d[count_q[$clog2(HEAD_BYTES)-1:0]] = s_axis_tdata_i;
    if (count_q >= CW'(fmc_pkg::TarMagicOffset) && count_q < CW'(fmc_pkg::CountMax))
      tar_d[3'(count_q - CW'(fmc_pkg::TarMagicOffset))] = s_axis_tdata_i;
    tail_d = {tail_q[TAIL_BYTES-2:0], s_axis_tdata_i};
    len    = (count_q < CW'(fmc_pkg::CountMax)) ? count_q + 1'b1 : count_q;
    count_d = s_axis_tlast_i ? '0 : len;
  end

  fmc_match #(.HEAD_BYTES(HEAD_BYTES), .TAIL_BYTES(TAIL_BYTES)) u_match (
    .head_i          (head_d),
    .tar_i           (tar_d),
    .tail_i          (tail_d),
    .len_i           (len),
    .check_trailer_i (check_q),
    .result_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      check_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) check_q <= cfg_data_i;
      if (accept) count_q <= count_d;
      if (accept && s_axis_tlast_i) out_valid_q <= 1'b1;
      else if (m_axis_tready_i)     out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      head_q <= head_d;
      tar_q  <= tar_d;
      tail_q <= tail_d;
      if (s_axis_tlast_i) res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, res_q};

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed under stall");
  a_nodet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !res_q.detected |-> res_q == '0)
    else $error("undetected result not zero");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(fmc_pkg::CountMax))
    else $error("count overflow");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast_i |=> count_q == '0 && m_axis_tvalid_o)
    else $error("last byte not closed");
endmodule
`default_nettype wire
